// ===== hdl/slch_pkg.sv =====
// Shared types and constants for the synced local clock.
// Used by slch_front, slch_back, the core and its checker. No dependencies.
`default_nettype none

package slch_pkg;

    localparam int TICKS_PER_SECOND = 1000;
    localparam int MILLI_W          = $clog2(TICKS_PER_SECOND + 1);

    localparam logic [31:0]        RESTORE_MIN_EPOCH = 32'd1700000000;
    localparam logic signed [11:0] ZONE_LIMIT        = 12'sd1440;
    localparam logic signed [11:0] ZONE_RESET        = 12'sd480;
    localparam logic [31:0]        SECS_PER_DAY      = 32'd86400;

    // floor(x / 675) for x < 2**25 (86400 = 128 * 675)
    localparam logic [25:0] DAY_MAGIC = 26'd50903317;
    localparam int          DAY_SHIFT = 35;
    // floor(x / 7) for x < 2**17
    localparam logic [17:0] WD_MAGIC  = 18'd149797;
    localparam int          WD_SHIFT  = 20;
    // floor(x / 3600) for x < 86400
    localparam logic [17:0] HR_MAGIC  = 18'd149131;
    localparam int          HR_SHIFT  = 29;
    // floor(x / 60) for x < 86400
    localparam logic [17:0] MIN_MAGIC = 18'd139811;
    localparam int          MIN_SHIFT = 23;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SYNC    = 2'd1,
        OP_RESTORE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_NEVER  = 2'd0,
        ST_APPROX = 2'd1,
        ST_SYNCED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BASE_KEEP = 2'd0,
        BASE_LOAD = 2'd1,
        BASE_SYNC = 2'd2
    } t_base_op;

    typedef struct packed {
        t_status            status;
        logic [31:0]        seconds;
        logic signed [11:0] zone;
        logic [3:0]         flags;
        t_base_op           base_op;
        logic [15:0]        base;
    } t_snap;

    typedef struct packed {
        logic [1:0]  sync_status;
        logic [31:0] utc_seconds;
        logic [15:0] local_day;
        logic [16:0] second_of_day;
        logic [2:0]  weekday;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic        rest_day;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/synced_local_clock_with_holidays_core.sv =====
// Top level of the synced local clock: front end, snapshot queue, calendar back end.
// Depends on slch_pkg, slch_front and slch_back.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------------
//  item in   | push / full        | i_opcode i_epoch_value i_tz_minutes i_holiday_*
//  result out| empty / pop        | o_sync_status o_utc_seconds o_local_day ...
//
// One item per cycle sustained while results are popped; one result per item, in order.
// From accept to result shown an item passes the snapshot queue, the four
// calendar pipeline stages (local seconds to quotients) and the result queue.
// Synchronous active-low reset; no clearing pass, input ready right after reset.
// A waiting result stalls the pipeline once two results are queued; full then
// rises when the two-entry snapshot queue fills.
`default_nettype none

module synced_local_clock_with_holidays_core
    import slch_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_epoch_value,
    input  wire logic [11:0] i_tz_minutes,
    input  wire logic [3:0]  i_holiday_flags,
    input  wire logic [15:0] i_holiday_day,
    output      logic        empty,
    input  wire logic        pop,
    output      logic [1:0]  o_sync_status,
    output      logic [31:0] o_utc_seconds,
    output      logic [15:0] o_local_day,
    output      logic [16:0] o_second_of_day,
    output      logic [2:0]  o_weekday,
    output      logic [4:0]  o_hour_now,
    output      logic [5:0]  o_minute_now,
    output      logic        o_rest_day
);

    logic    snap_valid, snap_pop;
    t_snap   snap;
    t_result result;

    slch_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_epoch_value   (i_epoch_value),
        .i_tz_minutes    (i_tz_minutes),
        .i_holiday_flags (i_holiday_flags),
        .i_holiday_day   (i_holiday_day),
        .o_snap_valid    (snap_valid),
        .o_snap          (snap),
        .i_snap_pop      (snap_pop)
    );

    slch_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_pop   (snap_pop),
        .empty        (empty),
        .pop          (pop),
        .o_result     (result)
    );

    assign o_sync_status   = result.sync_status;
    assign o_utc_seconds   = result.utc_seconds;
    assign o_local_day     = result.local_day;
    assign o_second_of_day = result.second_of_day;
    assign o_weekday       = result.weekday;
    assign o_hour_now      = result.hour_now;
    assign o_minute_now    = result.minute_now;
    assign o_rest_day      = result.rest_day;

endmodule

`default_nettype wire

// ===== hdl/slch_front.sv =====
// Front end: takes items, keeps the clock state and queues one snapshot per item.
// Depends on slch_pkg.
`default_nettype none

module slch_front
    import slch_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output      logic        full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_epoch_value,
    input  wire logic [11:0] i_tz_minutes,
    input  wire logic [3:0]  i_holiday_flags,
    input  wire logic [15:0] i_holiday_day,
    output      logic        o_snap_valid,
    output      t_snap       o_snap,
    input  wire logic        i_snap_pop
);

    t_status            r_status, n_status;
    logic [31:0]        r_seconds, n_seconds;
    logic [MILLI_W-1:0] r_milli, n_milli;
    logic signed [11:0] r_zone, n_zone;
    logic [3:0]         r_flags, n_flags;
    t_base_op           n_base_op;

    t_snap       r_queue [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        accept, pop;
    t_snap       n_snap;

    function automatic logic signed [11:0] f_clamp(input logic signed [11:0] z);
        logic signed [11:0] v;
        v = z;
        if (z < -ZONE_LIMIT) v = -ZONE_LIMIT;
        if (z > ZONE_LIMIT) v = ZONE_LIMIT;
        return v;
    endfunction

    assign full         = (r_cnt == 2'd2);
    assign accept       = push && !full;
    assign pop          = i_snap_pop && (r_cnt != 2'd0);
    assign o_snap_valid = (r_cnt != 2'd0);
    assign o_snap       = r_queue[r_rp];

    always_comb begin
        n_status  = r_status;
        n_seconds = r_seconds;
        n_milli   = r_milli;
        n_zone    = r_zone;
        n_flags   = r_flags;
        n_base_op = BASE_KEEP;
        case (t_opcode'(i_opcode))
            OP_TICK: begin
                if (r_milli == MILLI_W'(TICKS_PER_SECOND - 1)) begin
                    n_milli   = '0;
                    n_seconds = r_seconds + 32'd1;
                end else begin
                    n_milli = r_milli + MILLI_W'(1);
                end
            end
            OP_SYNC: begin
                n_seconds = i_epoch_value;
                n_milli   = '0;
                n_zone    = f_clamp(i_tz_minutes);
                n_flags   = i_holiday_flags;
                n_status  = ST_SYNCED;
                n_base_op = BASE_SYNC;
            end
            OP_RESTORE: begin
                if (i_epoch_value > RESTORE_MIN_EPOCH) begin
                    n_seconds = i_epoch_value;
                    n_milli   = '0;
                    n_zone    = f_clamp(i_tz_minutes);
                    n_flags   = i_holiday_flags;
                    n_status  = ST_APPROX;
                    n_base_op = BASE_LOAD;
                end
            end
            default: begin
            end
        endcase
        n_snap.status  = n_status;
        n_snap.seconds = n_seconds;
        n_snap.zone    = n_zone;
        n_snap.flags   = n_flags;
        n_snap.base_op = n_base_op;
        n_snap.base    = i_holiday_day;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_NEVER;
            r_seconds <= '0;
            r_milli   <= '0;
            r_zone    <= ZONE_RESET;
            r_flags   <= '0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (accept) begin
                r_status  <= n_status;
                r_seconds <= n_seconds;
                r_milli   <= n_milli;
                r_zone    <= n_zone;
                r_flags   <= n_flags;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wp] <= n_snap;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slch_back.sv =====
// Back end: four-stage calendar pipeline and the two-entry result queue.
// Depends on slch_pkg.
`default_nettype none

module slch_back
    import slch_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_snap_valid,
    input  wire t_snap i_snap,
    output      logic  o_snap_pop,
    output      logic  empty,
    input  wire logic  pop,
    output      t_result o_result
);

    logic adv, out_full, out_push, out_pop;

    // stage 1: local seconds
    logic        r_v1;
    logic [31:0] r_loc1, n_loc1, zone_ext, zone_secs;
    t_snap       r_snap1;
    // stage 2: day quotient product
    logic        r_v2;
    logic [50:0] r_prod2;
    logic [31:0] r_loc2;
    t_snap       r_snap2;
    // stage 3: day, second of day, base day
    logic        r_v3;
    logic [15:0] r_day3, n_day3, r_base3, n_base3, r_base;
    logic [16:0] r_sod3, n_sod3;
    t_status     r_status3;
    logic [31:0] r_seconds3;
    logic [3:0]  r_flags3;
    // stage 4: quotients and flag window
    logic        r_v4;
    logic [16:0] r_w4, n_w4, diff4;
    logic [34:0] p7, ph, pm;
    logic [14:0] r_q7;
    logic [4:0]  r_hour4;
    logic [10:0] r_mday4;
    logic        r_inwin4, r_flag4;
    logic [15:0] r_day4;
    logic [16:0] r_sod4;
    t_status     r_status4;
    logic [31:0] r_seconds4;
    // stage 5 into the result queue
    logic [2:0]  wd5;
    logic [5:0]  min5;
    logic        rest5;
    t_result     n_result;

    t_result     r_oq [2];
    logic        r_owp, r_orp;
    logic [1:0]  r_ocnt;

    assign out_full   = (r_ocnt == 2'd2);
    assign adv        = !(r_v4 && out_full);
    assign o_snap_pop = adv && i_snap_valid;
    assign out_push   = r_v4 && !out_full;
    assign out_pop    = pop && !empty;
    assign empty      = (r_ocnt == 2'd0);
    assign o_result   = r_oq[r_orp];

    assign zone_ext  = {{20{i_snap.zone[11]}}, i_snap.zone};
    assign zone_secs = (zone_ext << 6) - (zone_ext << 2);
    assign n_loc1    = i_snap.seconds + zone_secs;

    always_comb begin
        n_day3 = r_prod2[DAY_SHIFT +: 16];
        n_sod3 = 17'(r_loc2 - (32'(n_day3) * SECS_PER_DAY));
        case (r_snap2.base_op)
            BASE_LOAD: n_base3 = r_snap2.base;
            BASE_SYNC: n_base3 = n_day3;
            default:   n_base3 = r_base;
        endcase
    end

    assign n_w4  = 17'(r_day3) + 17'd4;
    assign p7    = 35'(n_w4) * 35'(WD_MAGIC);
    assign ph    = 35'(r_sod3) * 35'(HR_MAGIC);
    assign pm    = 35'(r_sod3) * 35'(MIN_MAGIC);
    assign diff4 = {1'b0, r_day3} - {1'b0, r_base3};

    always_comb begin
        wd5   = 3'(r_w4 - (17'(r_q7) * 17'd7));
        min5  = 6'(r_mday4 - (11'(r_hour4) * 11'd60));
        rest5 = r_inwin4 ? r_flag4 : (wd5 == 3'd0);
        n_result = '0;
        if (r_status4 != ST_NEVER) begin
            n_result.sync_status   = r_status4;
            n_result.utc_seconds   = r_seconds4;
            n_result.local_day     = r_day4;
            n_result.second_of_day = r_sod4;
            n_result.weekday       = wd5;
            n_result.hour_now      = r_hour4;
            n_result.minute_now    = min5;
            n_result.rest_day      = rest5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_base <= '0;
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (adv) begin
                r_v1 <= i_snap_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                if (r_v2) begin
                    r_base <= n_base3;
                end
            end
            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, out_push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_loc1     <= n_loc1;
            r_snap1    <= i_snap;
            r_prod2    <= 51'(r_loc1[31:7]) * 51'(DAY_MAGIC);
            r_loc2     <= r_loc1;
            r_snap2    <= r_snap1;
            r_day3     <= n_day3;
            r_sod3     <= n_sod3;
            r_base3    <= n_base3;
            r_status3  <= r_snap2.status;
            r_seconds3 <= r_snap2.seconds;
            r_flags3   <= r_snap2.flags;
            r_w4       <= n_w4;
            r_q7       <= p7[WD_SHIFT +: 15];
            r_hour4    <= ph[HR_SHIFT +: 5];
            r_mday4    <= pm[MIN_SHIFT +: 11];
            r_inwin4   <= !diff4[16] && (diff4[15:2] == 14'd0);
            r_flag4    <= r_flags3[diff4[1:0]];
            r_day4     <= r_day3;
            r_sod4     <= r_sod3;
            r_status4  <= r_status3;
            r_seconds4 <= r_seconds3;
        end
        if (out_push) begin
            r_oq[r_owp] <= n_result;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/slch_checker.sv =====
// Port-level checks for the synced local clock core, bound to the top level.
// Depends on slch_pkg and synced_local_clock_with_holidays_core.
`default_nettype none

module slch_checker
    import slch_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [1:0]  o_sync_status,
    input wire logic [31:0] o_utc_seconds,
    input wire logic [15:0] o_local_day,
    input wire logic [16:0] o_second_of_day,
    input wire logic [2:0]  o_weekday,
    input wire logic [4:0]  o_hour_now,
    input wire logic [5:0]  o_minute_now,
    input wire logic        o_rest_day
);

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not clear after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_utc_seconds) && $stable(o_local_day)
            && $stable(o_second_of_day) && $stable(o_rest_day))
        else $error("waiting item changed");

    a_unset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_sync_status == ST_NEVER |-> o_utc_seconds == 32'd0
            && o_local_day == 16'd0 && o_second_of_day == 17'd0 && o_weekday == 3'd0
            && o_hour_now == 5'd0 && o_minute_now == 6'd0 && !o_rest_day)
        else $error("unset clock reported nonzero time");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_sync_status == ST_NEVER || o_sync_status == ST_APPROX
                || o_sync_status == ST_SYNCED)
            && o_weekday < 3'd7 && o_hour_now < 5'd24
            && o_minute_now < 6'd60 && o_second_of_day < 17'd86400
            && o_hour_now == 5'(o_second_of_day / 17'd3600))
        else $error("calendar field out of range");

endmodule

bind synced_local_clock_with_holidays_core slch_checker u_slch_checker (.*);

`default_nettype wire

// ===== verif/synced_local_clock_with_holidays_core_test.sv =====
// Testbench for synced_local_clock_with_holidays_core: directed and random items,
// checked against an in-bench model of the clock state and calendar view.
// Depends on slch_pkg and the core RTL only.
module synced_local_clock_with_holidays_core_test;
    import slch_pkg::*;

    localparam logic [31:0] SUNDAY_NOON = 32'd1700395200;
    localparam logic [15:0] SUNDAY_DAY  = 16'd19680;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_opcode;
    logic [31:0] i_epoch_value;
    logic [11:0] i_tz_minutes;
    logic [3:0]  i_holiday_flags;
    logic [15:0] i_holiday_day;
    logic        empty;
    logic        pop;
    logic [1:0]  o_sync_status;
    logic [31:0] o_utc_seconds;
    logic [15:0] o_local_day;
    logic [16:0] o_second_of_day;
    logic [2:0]  o_weekday;
    logic [4:0]  o_hour_now;
    logic [5:0]  o_minute_now;
    logic        o_rest_day;

    synced_local_clock_with_holidays_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_epoch_value   (i_epoch_value),
        .i_tz_minutes    (i_tz_minutes),
        .i_holiday_flags (i_holiday_flags),
        .i_holiday_day   (i_holiday_day),
        .empty           (empty),
        .pop             (pop),
        .o_sync_status   (o_sync_status),
        .o_utc_seconds   (o_utc_seconds),
        .o_local_day     (o_local_day),
        .o_second_of_day (o_second_of_day),
        .o_weekday       (o_weekday),
        .o_hour_now      (o_hour_now),
        .o_minute_now    (o_minute_now),
        .o_rest_day      (o_rest_day)
    );

    // model of the clock state
    t_status            clk_status;
    logic [31:0]        clk_seconds;
    int unsigned        clk_milli;
    logic signed [11:0] clk_zone;
    logic [3:0]         clk_flags;
    logic [15:0]        clk_base_day;

    t_result calendar_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int results_checked;
    int mismatches;
    int syncs_taken;
    int restores_taken;
    int rest_days_seen;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [11:0] clamp_zone_minutes(logic [11:0] raw);
        int v;
        int lim;
        lim = ZONE_LIMIT;
        v = $signed(raw);
        if (v < -lim) v = -lim;
        if (v > lim) v = lim;
        return 12'(v);
    endfunction

    function automatic logic [31:0] local_seconds_at(logic [31:0] utc, logic signed [11:0] zone);
        int zmin;
        zmin = zone;
        return utc + 32'(zmin * 60);
    endfunction

    function automatic t_result apply_clock_item(t_opcode op, logic [31:0] epoch,
                                                 logic [11:0] tz, logic [3:0] flags,
                                                 logic [15:0] hday);
        logic [31:0] loc;
        logic [31:0] day;
        logic [31:0] sod;
        logic [31:0] wd;
        logic        rest;
        t_result     r;
        case (op)
            OP_TICK: begin
                clk_milli++;
                if (clk_milli >= TICKS_PER_SECOND) begin
                    clk_milli = 0;
                    clk_seconds++;
                end
            end
            OP_SYNC: begin
                clk_seconds  = epoch;
                clk_milli    = 0;
                clk_zone     = clamp_zone_minutes(tz);
                clk_flags    = flags;
                clk_base_day = 16'(local_seconds_at(epoch, clk_zone) / SECS_PER_DAY);
                clk_status   = ST_SYNCED;
                syncs_taken++;
            end
            OP_RESTORE: begin
                if (epoch > RESTORE_MIN_EPOCH) begin
                    clk_seconds  = epoch;
                    clk_milli    = 0;
                    clk_zone     = clamp_zone_minutes(tz);
                    clk_flags    = flags;
                    clk_base_day = hday;
                    clk_status   = ST_APPROX;
                    restores_taken++;
                end
            end
            default: ;
        endcase
        r = '0;
        if (clk_status != ST_NEVER) begin
            loc = local_seconds_at(clk_seconds, clk_zone);
            day = loc / SECS_PER_DAY;
            sod = loc % SECS_PER_DAY;
            wd  = (day + 32'd4) % 32'd7;
            if (day >= {16'd0, clk_base_day} && day <= {16'd0, clk_base_day} + 32'd3) begin
                rest = clk_flags[day - {16'd0, clk_base_day}];
            end else begin
                rest = (wd == 32'd0);
            end
            r.sync_status   = clk_status;
            r.utc_seconds   = clk_seconds;
            r.local_day     = 16'(day);
            r.second_of_day = 17'(sod);
            r.weekday       = 3'(wd);
            r.hour_now      = 5'(sod / 32'd3600);
            r.minute_now    = 6'((sod % 32'd3600) / 32'd60);
            r.rest_day      = rest;
            if (rest) rest_days_seen++;
        end
        return r;
    endfunction

    task automatic send_item(input t_opcode op, input logic [31:0] epoch, input logic [11:0] tz,
                             input logic [3:0] flags, input logic [15:0] hday);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_opcode        <= op;
        i_epoch_value   <= epoch;
        i_tz_minutes    <= tz;
        i_holiday_flags <= flags;
        i_holiday_day   <= hday;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
        calendar_q.push_back(apply_clock_item(op, epoch, tz, flags, hday));
    endtask

    task automatic check_calendar();
        t_result want;
        results_checked++;
        if (calendar_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: st=%0d utc=%0d day=%0d", o_sync_status,
                         o_utc_seconds, o_local_day);
        end else begin
            want = calendar_q.pop_front();
            if (o_sync_status !== want.sync_status || o_utc_seconds !== want.utc_seconds ||
                o_local_day !== want.local_day || o_second_of_day !== want.second_of_day ||
                o_weekday !== want.weekday || o_hour_now !== want.hour_now ||
                o_minute_now !== want.minute_now || o_rest_day !== want.rest_day) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at result %0d", results_checked);
                    $display("  want st=%0d utc=%0d day=%0d sod=%0d wd=%0d h=%0d m=%0d rest=%0d",
                             want.sync_status, want.utc_seconds, want.local_day,
                             want.second_of_day, want.weekday, want.hour_now,
                             want.minute_now, want.rest_day);
                    $display("  got  st=%0d utc=%0d day=%0d sod=%0d wd=%0d h=%0d m=%0d rest=%0d",
                             o_sync_status, o_utc_seconds, o_local_day, o_second_of_day,
                             o_weekday, o_hour_now, o_minute_now, o_rest_day);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) check_calendar();
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [31:0] random_epoch();
        case ($urandom_range(4))
            0, 1:    return $urandom;
            2:       return 32'hFFFF_FFFF - $urandom_range(200000);
            3:       return $urandom_range(200000);
            default: return 32'(SECS_PER_DAY * $urandom_range(49000)) - $urandom_range(3);
        endcase
    endfunction

    function automatic logic [11:0] random_zone();
        case ($urandom_range(5))
            0, 1, 2: return 12'(int'($urandom_range(2880)) - 1440);
            3:       return 12'($urandom);
            4:       return $urandom_range(1) ? 12'(1440) : 12'(-1440);
            default: return $urandom_range(1) ? 12'(1441) : 12'(-1441);
        endcase
    endfunction

    task automatic test_never_set();
        send_item(OP_TICK, 32'd0, 12'd0, 4'd0, 16'd0);
        send_item(OP_NONE, 32'h1234_5678, 12'h0AB, 4'hF, 16'hBEEF);
        send_item(OP_RESTORE, RESTORE_MIN_EPOCH, 12'd0, 4'hF, 16'hFFFF);
        send_item(OP_TICK, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 16'hFFFF);
    endtask

    task automatic test_zone_clamp();
        send_item(OP_SYNC, 32'd0, 12'd0, 4'd0, 16'd0);
        send_item(OP_SYNC, 32'd0, 12'(-1440), 4'd1, 16'd0);
        send_item(OP_SYNC, 32'd86399, 12'h800, 4'd2, 16'd0);
        send_item(OP_SYNC, 32'd1000, 12'h7FF, 4'd4, 16'd0);
        send_item(OP_SYNC, 32'hFFFF_FFFF, 12'(1441), 4'd8, 16'd0);
        send_item(OP_SYNC, 32'd12345678, 12'(-1441), 4'd3, 16'd0);
        send_item(OP_SYNC, 32'hFFFF_FFFF, 12'(1440), 4'hF, 16'd0);
    endtask

    task automatic test_holiday_window();
        send_item(OP_SYNC, SUNDAY_NOON, 12'd0, 4'd0, 16'd0);
        send_item(OP_RESTORE, SUNDAY_NOON, 12'd0, 4'b1010, SUNDAY_DAY - 16'd1);
        send_item(OP_RESTORE, SUNDAY_NOON, 12'd0, 4'b0111, SUNDAY_DAY - 16'd3);
        send_item(OP_RESTORE, SUNDAY_NOON, 12'd0, 4'hF, SUNDAY_DAY - 16'd4);
        send_item(OP_RESTORE, SUNDAY_NOON, 12'd0, 4'hF, SUNDAY_DAY + 16'd1);
        send_item(OP_RESTORE, SUNDAY_NOON + SECS_PER_DAY, 12'd0, 4'd0, 16'd0);
    endtask

    task automatic test_restore_rules();
        send_item(OP_SYNC, 32'd86399, 12'd0, 4'h5, 16'd0);
        send_item(OP_RESTORE, 32'hFFFF_FFFF, 12'h7FF, 4'h5, 16'hFFFF);
        send_item(OP_RESTORE, RESTORE_MIN_EPOCH, 12'd60, 4'hA, 16'h0000);
        send_item(OP_RESTORE, RESTORE_MIN_EPOCH + 32'd1, 12'd480, 4'hC, 16'h5555);
        send_item(OP_NONE, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 16'hFFFF);
    endtask

    // sub-second count must restart on restore and carry exactly at 1000 ticks,
    // here across the 32-bit seconds wrap
    task automatic test_tick_carry();
        send_item(OP_SYNC, 32'hFFFF_FFFF, 12'd0, 4'h1, 16'd0);
        repeat (10) send_item(OP_TICK, $urandom, 12'($urandom), 4'($urandom), 16'($urandom));
        send_item(OP_RESTORE, 32'hFFFF_FFFF, 12'd0, 4'h1, 16'd49710);
        repeat (1000) send_item(OP_TICK, $urandom, 12'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic test_random_traffic(input int n_items);
        int          first;
        int          pick;
        logic [31:0] epoch;
        logic [11:0] tz;
        logic [15:0] hday;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            tz   = random_zone();
            if (pick < 55) begin
                send_item(OP_SYNC, random_epoch(), tz, 4'($urandom), 16'($urandom));
            end else if (pick < 85) begin
                if ($urandom_range(9) < 8)
                    epoch = $urandom_range(32'hFFFF_FFFF, RESTORE_MIN_EPOCH + 32'd1);
                else
                    epoch = $urandom_range(RESTORE_MIN_EPOCH, RESTORE_MIN_EPOCH - 32'd5);
                if ($urandom_range(9) < 6)
                    hday = 16'(local_seconds_at(epoch, clamp_zone_minutes(tz)) / SECS_PER_DAY)
                           - 16'($urandom_range(5));
                else
                    hday = 16'($urandom);
                send_item(OP_RESTORE, epoch, tz, 4'($urandom), hday);
            end else begin
                send_item(OP_NONE, $urandom, 12'($urandom), 4'($urandom), 16'($urandom));
            end
            repeat ($urandom_range(15))
                send_item(OP_TICK, $urandom, 12'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         <= 1'b0;
        push            <= 1'b0;
        pop             <= 1'b0;
        i_opcode        <= OP_TICK;
        i_epoch_value   <= '0;
        i_tz_minutes    <= '0;
        i_holiday_flags <= '0;
        i_holiday_day   <= '0;
        clk_status      = ST_NEVER;
        clk_seconds     = '0;
        clk_milli       = 0;
        clk_zone        = ZONE_RESET;
        clk_flags       = '0;
        clk_base_day    = '0;
        tx_idle_pct     = 12;
        rx_idle_pct     = 54;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        syncs_taken     = 0;
        restores_taken  = 0;
        rest_days_seen  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_never_set();
        test_zone_clamp();
        test_holiday_window();
        test_restore_rules();
        test_tick_carry();
        test_random_traffic(20);
        tx_idle_pct = 54;
        rx_idle_pct = 12;
        test_random_traffic(20);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(20);
        push <= 1'b0;

        while (calendar_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
                 results_checked, mismatches);
        $display("%0d syncs and %0d restores taken, %0d rest days reported", syncs_taken,
                 restores_taken, rest_days_seen);
        if (mismatches == 0 && calendar_q.size() == 0) begin
            $display("synced_local_clock_with_holidays_core test passed");
        end else begin
            $display("synced_local_clock_with_holidays_core test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("synced_local_clock_with_holidays_core test failed");
        $finish;
    end

endmodule

// ===== synced_local_clock_with_holidays_core.f =====
hdl/slch_pkg.sv
hdl/slch_front.sv
hdl/slch_back.sv
hdl/synced_local_clock_with_holidays_core.sv
hdl/slch_checker.sv
verif/synced_local_clock_with_holidays_core_test.sv
